### sv/smtp_pkg.sv
// Shared types and constants for the stack map table parser.
// Used by every module of the block; depends on nothing else.
package smtp_pkg;

    // one input item: a raw attribute byte and its end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [2:0]  frame_kind;
        logic [15:0] frame_offset;
        logic [15:0] count_value;
        logic [7:0]  type_tag;
        logic [15:0] type_operand;
        logic        has_operand;
        logic        table_done;
        logic [1:0]  status;
    } out_item_t;

    // parse position within the attribute
    typedef enum logic [4:0] {
        PH_CNT_HI   = 5'd0,
        PH_CNT_LO   = 5'd1,
        PH_FTAG     = 5'd2,
        PH_DELTA_HI = 5'd3,
        PH_DELTA_LO = 5'd4,
        PH_LCNT_HI  = 5'd5,
        PH_LCNT_LO  = 5'd6,
        PH_SCNT_HI  = 5'd7,
        PH_SCNT_LO  = 5'd8,
        PH_VTAG     = 5'd9,
        PH_VOP_HI   = 5'd10,
        PH_VOP_LO   = 5'd11,
        PH_DONE     = 5'd12,
        PH_SKIP     = 5'd13
    } phase_t;

    // record kinds
    localparam logic [2:0] REC_TABLE_COUNT = 3'd0;
    localparam logic [2:0] REC_HEADER      = 3'd1;
    localparam logic [2:0] REC_LOCAL_COUNT = 3'd2;
    localparam logic [2:0] REC_STACK_COUNT = 3'd3;
    localparam logic [2:0] REC_LOCAL_TYPE  = 3'd4;
    localparam logic [2:0] REC_STACK_TYPE  = 3'd5;
    localparam logic [2:0] REC_STATUS      = 3'd6;

    // frame kinds
    localparam logic [2:0] FK_SAME    = 3'd0;
    localparam logic [2:0] FK_SAME_L1 = 3'd1;
    localparam logic [2:0] FK_CHOP    = 3'd2;
    localparam logic [2:0] FK_APPEND  = 3'd3;
    localparam logic [2:0] FK_FULL    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_TAG   = 2'd1;
    localparam logic [1:0] ST_TRAILING  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // frame tag boundaries
    localparam logic [7:0] TAG_SAME_L1_MIN = 8'd64;
    localparam logic [7:0] TAG_RESERVED    = 8'd128;
    localparam logic [7:0] TAG_SAME_L1_EXT = 8'd247;
    localparam logic [7:0] TAG_CHOP_MIN    = 8'd248;
    localparam logic [7:0] TAG_SAME_EXT    = 8'd251;
    localparam logic [7:0] TAG_APPEND_MIN  = 8'd252;
    localparam logic [7:0] TAG_FULL        = 8'd255;

    // verification types that carry a 16-bit operand
    localparam logic [7:0] VT_OBJECT = 8'd7;
    localparam logic [7:0] VT_UNINIT = 8'd8;

endpackage

### sv/smtp_in_stage.sv
// Input register of the stack map table parser.
// Holds one accepted item until the parser consumes it; uses smtp_pkg.
module smtp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  smtp_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output smtp_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    smtp_pkg::in_item_t item_reg;

    // free when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/smtp_parser.sv
// Parse state and one-byte step of the stack map table parser.
// Consumes one held item per step and forms at most one record; uses smtp_pkg.
module smtp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  smtp_pkg::in_item_t item,
    output logic               rec_valid,
    output smtp_pkg::out_item_t rec
);

    smtp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] frames_reg, frames_next;
    logic [15:0] locals_reg, locals_next;
    logic [15:0] stack_reg, stack_next;
    logic [2:0]  fkind_reg, fkind_next;
    logic [15:0] delta_reg, delta_next;
    logic [7:0]  ptag_reg, ptag_next;
    logic        in_stack_reg, in_stack_next;
    logic        err_reg, err_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= smtp_pkg::PH_CNT_HI;
            hold_reg     <= '0;
            frames_reg   <= '0;
            locals_reg   <= '0;
            stack_reg    <= '0;
            fkind_reg    <= '0;
            delta_reg    <= '0;
            ptag_reg     <= '0;
            in_stack_reg <= 1'b0;
            err_reg      <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            hold_reg     <= hold_next;
            frames_reg   <= frames_next;
            locals_reg   <= locals_next;
            stack_reg    <= stack_next;
            fkind_reg    <= fkind_next;
            delta_reg    <= delta_next;
            ptag_reg     <= ptag_next;
            in_stack_reg <= in_stack_next;
            err_reg      <= err_next;
        end
    end

    // one parse step
    always_comb begin
        logic [7:0]  b;
        logic        last;
        logic [15:0] word;
        logic [15:0] frames_dec;
        logic [15:0] locals_dec;
        logic [15:0] stack_dec;
        logic [1:0]  err;
        logic        have;
        logic [2:0]  e_kind;
        logic [15:0] e_cnt;
        logic [7:0]  e_ttag;
        logic [15:0] e_top;
        logic        e_hop;
        logic [2:0]  type_kind;

        b          = item.data_byte;
        last       = item.last_byte;
        word       = {hold_reg, b};
        frames_dec = frames_reg - 16'd1;
        locals_dec = locals_reg - 16'd1;
        stack_dec  = stack_reg - 16'd1;
        type_kind  = in_stack_reg ? smtp_pkg::REC_STACK_TYPE : smtp_pkg::REC_LOCAL_TYPE;
        err        = smtp_pkg::ST_OK;
        have       = 1'b0;
        e_kind     = smtp_pkg::REC_TABLE_COUNT;
        e_cnt      = '0;
        e_ttag     = '0;
        e_top      = '0;
        e_hop      = 1'b0;

        phase_next    = phase_reg;
        hold_next     = hold_reg;
        frames_next   = frames_reg;
        locals_next   = locals_reg;
        stack_next    = stack_reg;
        fkind_next    = fkind_reg;
        delta_next    = delta_reg;
        ptag_next     = ptag_reg;
        in_stack_next = in_stack_reg;
        err_next      = err_reg;
        rec           = '0;

        if (step_en && !(phase_reg == smtp_pkg::PH_SKIP || err_reg)) begin
            case (phase_reg)
                smtp_pkg::PH_CNT_HI, smtp_pkg::PH_DELTA_HI, smtp_pkg::PH_LCNT_HI,
                smtp_pkg::PH_SCNT_HI, smtp_pkg::PH_VOP_HI: begin
                    hold_next  = b;
                    phase_next = smtp_pkg::phase_t'(phase_reg + 5'd1);
                end
                smtp_pkg::PH_CNT_LO: begin
                    frames_next = word;
                    have        = 1'b1;
                    e_kind      = smtp_pkg::REC_TABLE_COUNT;
                    e_cnt       = word;
                    phase_next  = (word == 16'd0) ? smtp_pkg::PH_DONE : smtp_pkg::PH_FTAG;
                end
                smtp_pkg::PH_FTAG: begin
                    locals_next = '0;
                    stack_next  = '0;
                    if (b < smtp_pkg::TAG_SAME_L1_MIN) begin
                        fkind_next  = smtp_pkg::FK_SAME;
                        delta_next  = {8'd0, b};
                        have        = 1'b1;
                        e_kind      = smtp_pkg::REC_HEADER;
                        frames_next = frames_dec;
                        phase_next  = (frames_dec == 16'd0) ? smtp_pkg::PH_DONE
                                                            : smtp_pkg::PH_FTAG;
                    end else if (b < smtp_pkg::TAG_RESERVED) begin
                        fkind_next    = smtp_pkg::FK_SAME_L1;
                        delta_next    = {8'd0, b - smtp_pkg::TAG_SAME_L1_MIN};
                        have          = 1'b1;
                        e_kind        = smtp_pkg::REC_HEADER;
                        stack_next    = 16'd1;
                        in_stack_next = 1'b1;
                        phase_next    = smtp_pkg::PH_VTAG;
                    end else if (b == smtp_pkg::TAG_SAME_L1_EXT) begin
                        fkind_next = smtp_pkg::FK_SAME_L1;
                        phase_next = smtp_pkg::PH_DELTA_HI;
                    end else if (b >= smtp_pkg::TAG_CHOP_MIN && b < smtp_pkg::TAG_SAME_EXT) begin
                        fkind_next  = smtp_pkg::FK_CHOP;
                        locals_next = {8'd0, smtp_pkg::TAG_SAME_EXT - b};
                        phase_next  = smtp_pkg::PH_DELTA_HI;
                    end else if (b == smtp_pkg::TAG_SAME_EXT) begin
                        fkind_next = smtp_pkg::FK_SAME;
                        phase_next = smtp_pkg::PH_DELTA_HI;
                    end else if (b >= smtp_pkg::TAG_APPEND_MIN && b < smtp_pkg::TAG_FULL) begin
                        fkind_next  = smtp_pkg::FK_APPEND;
                        locals_next = {8'd0, b - smtp_pkg::TAG_SAME_EXT};
                        phase_next  = smtp_pkg::PH_DELTA_HI;
                    end else if (b == smtp_pkg::TAG_FULL) begin
                        fkind_next = smtp_pkg::FK_FULL;
                        phase_next = smtp_pkg::PH_DELTA_HI;
                    end else begin
                        err = smtp_pkg::ST_BAD_TAG;
                    end
                end
                smtp_pkg::PH_DELTA_LO: begin
                    delta_next = word;
                    have       = 1'b1;
                    e_kind     = smtp_pkg::REC_HEADER;
                    if (fkind_reg == smtp_pkg::FK_CHOP || fkind_reg == smtp_pkg::FK_APPEND) begin
                        e_cnt = locals_reg;
                    end
                    if (fkind_reg == smtp_pkg::FK_SAME_L1) begin
                        stack_next    = 16'd1;
                        in_stack_next = 1'b1;
                        phase_next    = smtp_pkg::PH_VTAG;
                    end else if (fkind_reg == smtp_pkg::FK_APPEND) begin
                        in_stack_next = 1'b0;
                        phase_next    = smtp_pkg::PH_VTAG;
                    end else if (fkind_reg == smtp_pkg::FK_FULL) begin
                        phase_next = smtp_pkg::PH_LCNT_HI;
                    end else begin
                        locals_next = '0;
                        frames_next = frames_dec;
                        phase_next  = (frames_dec == 16'd0) ? smtp_pkg::PH_DONE
                                                            : smtp_pkg::PH_FTAG;
                    end
                end
                smtp_pkg::PH_LCNT_LO: begin
                    locals_next   = word;
                    have          = 1'b1;
                    e_kind        = smtp_pkg::REC_LOCAL_COUNT;
                    e_cnt         = word;
                    in_stack_next = 1'b0;
                    phase_next    = (word == 16'd0) ? smtp_pkg::PH_SCNT_HI : smtp_pkg::PH_VTAG;
                end
                smtp_pkg::PH_SCNT_LO: begin
                    stack_next    = word;
                    have          = 1'b1;
                    e_kind        = smtp_pkg::REC_STACK_COUNT;
                    e_cnt         = word;
                    in_stack_next = 1'b1;
                    if (word == 16'd0) begin
                        frames_next = frames_dec;
                        phase_next  = (frames_dec == 16'd0) ? smtp_pkg::PH_DONE
                                                            : smtp_pkg::PH_FTAG;
                    end else begin
                        phase_next = smtp_pkg::PH_VTAG;
                    end
                end
                smtp_pkg::PH_VTAG, smtp_pkg::PH_VOP_LO: begin
                    if (phase_reg == smtp_pkg::PH_VTAG) begin
                        ptag_next = b;
                    end
                    if (phase_reg == smtp_pkg::PH_VTAG &&
                        (b == smtp_pkg::VT_OBJECT || b == smtp_pkg::VT_UNINIT)) begin
                        phase_next = smtp_pkg::PH_VOP_HI;
                    end else begin
                        // type item complete
                        have   = 1'b1;
                        e_kind = type_kind;
                        if (phase_reg == smtp_pkg::PH_VTAG) begin
                            e_ttag = b;
                        end else begin
                            e_ttag = ptag_reg;
                            e_top  = word;
                            e_hop  = 1'b1;
                        end
                        if (in_stack_reg) begin
                            stack_next = stack_dec;
                            if (stack_dec == 16'd0) begin
                                frames_next = frames_dec;
                                phase_next  = (frames_dec == 16'd0) ? smtp_pkg::PH_DONE
                                                                    : smtp_pkg::PH_FTAG;
                            end else begin
                                phase_next = smtp_pkg::PH_VTAG;
                            end
                        end else begin
                            locals_next = locals_dec;
                            if (locals_dec != 16'd0) begin
                                phase_next = smtp_pkg::PH_VTAG;
                            end else if (fkind_reg == smtp_pkg::FK_FULL) begin
                                phase_next = smtp_pkg::PH_SCNT_HI;
                            end else begin
                                frames_next = frames_dec;
                                phase_next  = (frames_dec == 16'd0) ? smtp_pkg::PH_DONE
                                                                    : smtp_pkg::PH_FTAG;
                            end
                        end
                    end
                end
                smtp_pkg::PH_DONE: begin
                    err = smtp_pkg::ST_TRAILING;
                end
                default: begin
                    err = smtp_pkg::ST_TRUNCATED;
                end
            endcase

            // assemble the record from the updated frame context
            rec.record_kind  = e_kind;
            rec.count_value  = e_cnt;
            rec.type_tag     = e_ttag;
            rec.type_operand = e_top;
            rec.has_operand  = e_hop;
            if (e_kind inside {[smtp_pkg::REC_HEADER:smtp_pkg::REC_STACK_TYPE]}) begin
                rec.frame_kind   = fkind_next;
                rec.frame_offset = delta_next;
            end

            // error and end-of-attribute overrides
            if (err != smtp_pkg::ST_OK) begin
                rec             = '0;
                rec.record_kind = smtp_pkg::REC_STATUS;
                rec.table_done  = 1'b1;
                rec.status      = err;
                have            = 1'b1;
                if (!last) begin
                    phase_next = smtp_pkg::PH_SKIP;
                    err_next   = 1'b1;
                end
            end else if (last) begin
                if (!have) begin
                    rec             = '0;
                    rec.record_kind = smtp_pkg::REC_STATUS;
                    have            = 1'b1;
                end
                rec.table_done = 1'b1;
                rec.status     = (phase_next == smtp_pkg::PH_DONE) ? smtp_pkg::ST_OK
                                                                   : smtp_pkg::ST_TRUNCATED;
            end
        end

        // last byte re-arms for the next attribute
        if (step_en && last) begin
            phase_next    = smtp_pkg::PH_CNT_HI;
            hold_next     = '0;
            frames_next   = '0;
            locals_next   = '0;
            stack_next    = '0;
            fkind_next    = '0;
            delta_next    = '0;
            ptag_next     = '0;
            in_stack_next = 1'b0;
            err_next      = 1'b0;
        end

        rec_valid = have;
    end

endmodule

### sv/stack_map_table_parser_top.sv
// Top level of the stack map table parser: input register, parse step, result register.
// Depends on smtp_pkg, smtp_in_stage and smtp_parser.
//
// Usage: attribute body bytes enter on the s_ channel one item at a time,
// with last_byte set on the final byte. Each byte yields zero or one record
// on the m_ channel (table count, frame header, counts, verification types,
// or a status-only record). The record that ends an attribute carries
// table_done, with status ok, invalid tag, trailing bytes or truncated.
// After an error, bytes are dropped silently until the last byte.
// A byte waits in the input register until the result register is free or drains;
// its record is then registered in the result register and is valid on m_ from
// there until the receiver takes it.
// Throughput: one byte per cycle unless the receiver stalls; the whole parse
// step is one pass of combinational logic between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to expecting the frame count high byte.
// When the receiver stalls, the result register holds its record and the
// input register holds one more byte; s_ready then stays low until m_ready.
module stack_map_table_parser_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smtp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output smtp_pkg::out_item_t m_item
);

    logic                advance;
    logic                held_valid;
    smtp_pkg::in_item_t  held_item;
    logic                rec_valid;
    smtp_pkg::out_item_t rec;
    logic                out_valid_reg, out_valid_next;
    smtp_pkg::out_item_t out_item_reg;

    // step when a byte is held and the result register is free or drains this cycle
    assign advance = held_valid && (!out_valid_reg || m_ready);

    smtp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (held_valid),
        .item       (held_item)
    );

    smtp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .item      (held_item),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // result register
    assign out_valid_next = advance ? rec_valid : (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && rec_valid) begin
            out_item_reg <= rec;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // a nonzero status only on the record that ends the attribute
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.table_done |-> m_item.status == smtp_pkg::ST_OK)
        else $error("status set on a record that does not end the attribute");

    // a status-only record always ends the attribute
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.record_kind == smtp_pkg::REC_STATUS |-> m_item.table_done)
        else $error("status-only record without table_done");

    // an operand only travels with a type record
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.has_operand |->
            (m_item.record_kind == smtp_pkg::REC_LOCAL_TYPE ||
             m_item.record_kind == smtp_pkg::REC_STACK_TYPE))
        else $error("operand flag on a non-type record");

    // a held byte that cannot step is still held next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid && !advance |=> held_valid)
        else $error("input byte lost while the result register was full");

endmodule
